### hdl/assert_macros.svh
// assertion helpers shared by the rtl, clocked on clk with rst_n low as reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cause at one edge implies effect at the next
`define CHK_NEXT(label, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error(msg);

`endif

### hdl/fcpu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcpu_pkg
// types, opcodes and helpers of the dual-stack core
// ----------------------------------------------------------------------------
package fcpu_pkg;

  localparam int STACK_DEPTH_DEF = 8;
  localparam int MEM_WORDS_DEF   = 64;

  localparam logic [17:0] DECODE_KEY = 18'h15555;
  localparam logic [17:0] RAM_TOP    = 18'h0007F;
  localparam logic [17:0] ROM_TOP    = 18'h000FF;

  typedef enum logic [1:0] {
    CMD_STEP     = 2'd0,
    CMD_LOAD_ROM = 2'd1,
    CMD_LOAD_RAM = 2'd2,
    CMD_SET_PC   = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    OP_RET, OP_EX, OP_JUMP, OP_CALL, OP_UNEXT, OP_NEXT, OP_IF, OP_MIF,
    OP_FETCH_P, OP_FETCH_PLUS, OP_FETCH_B, OP_FETCH_A,
    OP_STORE_P, OP_STORE_PLUS, OP_STORE_B, OP_STORE_A,
    OP_MUL_STEP, OP_SHL, OP_SHR, OP_NOT, OP_ADD, OP_AND, OP_XOR, OP_DROP,
    OP_DUP, OP_POP, OP_OVER, OP_READ_A, OP_NOP, OP_PUSH, OP_SET_B, OP_SET_A
  } op_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  load_address;
    logic [17:0] load_data;
    logic [9:0]  start_address;
    logic [17:0] io_read_data;
  } in_t;

  typedef struct packed {
    logic        io_access;
    logic        io_is_write;
    logic [17:0] io_address;
    logic [17:0] io_write_data;
    logic        rom_write_attempt;
    logic [9:0]  program_counter;
    logic [17:0] top_of_stack;
  } out_t;

  // one ring's request for the current step
  typedef struct packed {
    logic        push;
    logic        pop;
    logic [17:0] data;
  } ring_ctl_t;

  // word offset below 128 folded onto the memory depth (depth 16 or more)
  function automatic logic [8:0] mem_fold(input logic [6:0] v, input int unsigned m);
    logic [8:0] r;
    logic [8:0] mm;
    r  = {2'b00, v};
    mm = m[8:0];
    for (int i = 0; i < 8; i++) begin
      if (r >= mm) r = r - mm;
    end
    return r;
  endfunction

endpackage

### hdl/fcpu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcpu_ram
// generic ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module fcpu_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

### hdl/fcpu_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcpu_ring
// circular stack in a ram, reads zero until an entry is first pushed
// ----------------------------------------------------------------------------
module fcpu_ring #(
  parameter int DEPTH = fcpu_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fcpu_pkg::ring_ctl_t ctl,
  output logic [17:0]         pop_data
);
  import fcpu_pkg::*;

  localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [SW-1:0] LAST = SW'(DEPTH - 1);

  logic [SW-1:0]    idx_r, idx_nxt, rd_addr;
  logic [DEPTH-1:0] vld_r;
  logic             vq_r;
  logic [17:0]      rd_q;

  // entry under the index, i.e. the one a pop returns
  assign rd_addr  = (idx_r == '0) ? LAST : idx_r - SW'(1);
  assign pop_data = vq_r ? rd_q : 18'd0;

  always_comb begin
    idx_nxt = idx_r;
    if (ctl.push) idx_nxt = (idx_r == LAST) ? '0 : idx_r + SW'(1);
    else if (ctl.pop) idx_nxt = rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= '0;
      vq_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (ctl.push) vld_r[idx_r] <= 1'b1;
      vq_r <= vld_r[rd_addr];
    end
  end

  fcpu_ram #(.WIDTH(18), .DEPTH(DEPTH)) u_mem (
    .clk(clk), .wr_en(ctl.push), .wr_addr(idx_r), .wr_data(ctl.data),
    .rd_addr(rd_addr), .rd_data(rd_q)
  );
endmodule

### hdl/dual_stack_forth_cpu_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stack_forth_cpu_core
// 18-bit dual-stack core, one command beat in, one status beat out
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall   | in_t  (cmd, loads, pc, io data)
//  out_    | output    | out_valid / out_stall | out_t (io access, flags, P, T)
//
// each beat is accepted and then executed: the accept edge issues the ram, rom and ring
// reads addressed from the current registers, the next edge executes
// reset (rst_n low, synchronous) clears the architectural and handshake registers, ring indexes
// and ring valid bits, not the payload registers; ram and rom hold nothing defined until loaded
// a stalled output beat holds; a new beat is taken once no beat is executing and
// the output register is free or drains at the same edge
`include "assert_macros.svh"

module dual_stack_forth_cpu_core #(
  parameter int STACK_DEPTH = fcpu_pkg::STACK_DEPTH_DEF,
  parameter int MEM_WORDS   = fcpu_pkg::MEM_WORDS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  fcpu_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output fcpu_pkg::out_t out_data
);
  import fcpu_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  typedef enum logic [1:0] {GO_ON, GO_FETCH, GO_JUMP, GO_RESTART} go_t;

  // architectural registers
  logic [17:0] t_r, t_nxt, s_r, s_nxt, r_r, r_nxt, a_r, a_nxt, b_r, b_nxt;
  logic        c_r, c_nxt;
  logic [9:0]  pc_r, pc_nxt;
  logic [17:0] iw_r, iw_nxt;
  logic [2:0]  slot_r, slot_nxt;

  // handshake and the beat under execution
  in_t   item_r;
  logic  busy_r, accept;
  out_t  out_r, o;
  logic  out_valid_r, out_valid_nxt;

  // decode
  logic        is_fetch, ext;
  logic [1:0]  k;
  logic [17:0] dec;
  op_t         op;
  go_t         go;

  // memory path
  logic [17:0] maddr, rdv, sum;
  logic        m_ram, m_rom, m_io;
  logic [8:0]  mfold, lfold;
  logic [AW-1:0] midx, lidx, ram_wa;
  logic [17:0] ram_q, rom_q, ram_wd;
  logic        ram_we, rom_we;
  logic [9:0]  pc_inc;
  logic [17:0] a_inc;
  logic [19:0] s20;

  ring_ctl_t   dctl, rctl;
  logic [17:0] d_q, r_q;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = busy_r || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // slot decode from the held word; slot 1..4 executes slot 0..3
  assign is_fetch = (slot_r == 3'd0) || (slot_r > 3'd4);
  assign k        = 2'(slot_r - 3'd1);
  assign dec      = iw_r ^ DECODE_KEY;
  assign ext      = pc_r[9];

  always_comb begin
    unique case (k)
      2'd0:    op = op_t'(dec[17:13]);
      2'd1:    op = op_t'(dec[12:8]);
      2'd2:    op = op_t'(dec[7:3]);
      default: op = op_t'({dec[2:0], 2'b00});
    endcase
  end

  // address of the step's memory access, same in the read and execute cycles
  always_comb begin
    maddr = {9'd0, pc_r[8:0]};
    if (!is_fetch) begin
      if (op == OP_FETCH_PLUS || op == OP_STORE_PLUS) maddr = {9'd0, a_r[8:0]};
      else if (op == OP_FETCH_B || op == OP_STORE_B) maddr = b_r;
      else if (op == OP_FETCH_A || op == OP_STORE_A) maddr = a_r;
    end
  end

  assign m_ram = maddr <= RAM_TOP;
  assign m_rom = !m_ram && (maddr <= ROM_TOP);
  assign m_io  = !m_ram && !m_rom;
  assign mfold = mem_fold(maddr[6:0], MEM_WORDS);
  assign lfold = mem_fold({1'b0, item_r.load_address}, MEM_WORDS);
  assign midx  = mfold[AW-1:0];
  assign lidx  = lfold[AW-1:0];
  assign rdv   = m_ram ? ram_q : (m_rom ? rom_q : item_r.io_read_data);

  // auto-increment wraps inside the 128-word region
  always_comb begin
    pc_inc = pc_r;
    if (pc_r[8:0] <= 9'h07F) pc_inc = {pc_r[9], 2'b00, pc_r[6:0] + 7'd1};
    else if (pc_r[8:0] <= 9'h0FF) pc_inc = {pc_r[9], 2'b01, pc_r[6:0] + 7'd1};
    a_inc = a_r;
    if (a_r[8:0] <= 9'h07F) a_inc = {11'd0, a_r[6:0] + 7'd1};
    else if (a_r[8:0] <= 9'h0FF) a_inc = {10'd0, 1'b1, a_r[6:0] + 7'd1};
  end

  // execute: all state updates for the beat
  always_comb begin
    t_nxt = t_r; s_nxt = s_r; r_nxt = r_r; a_nxt = a_r; b_nxt = b_r;
    c_nxt = c_r; pc_nxt = pc_r; iw_nxt = iw_r; slot_nxt = slot_r;
    dctl = '0; rctl = '0; o = '0; go = GO_ON;
    ram_we = 1'b0; ram_wa = midx; ram_wd = t_r; rom_we = 1'b0;
    s20 = 20'd0; sum = 18'd0;
    if (busy_r) begin
      unique case (cmd_t'(item_r.cmd))
        CMD_STEP: begin
          if (is_fetch) begin
            iw_nxt = rdv; slot_nxt = 3'd1; pc_nxt = pc_inc;
            o.io_access = m_io;
            o.io_address = m_io ? maddr : 18'd0;
          end else begin
            unique case (op)
              OP_RET: begin
                pc_nxt = r_r[9:0]; r_nxt = r_q; rctl.pop = 1'b1; go = GO_FETCH;
              end
              OP_EX: begin
                pc_nxt = r_r[9:0]; r_nxt = {8'd0, pc_r}; go = GO_FETCH;
              end
              OP_JUMP: go = GO_JUMP;
              OP_CALL: begin
                rctl.push = 1'b1; rctl.data = r_r; r_nxt = {8'd0, pc_r}; go = GO_JUMP;
              end
              OP_UNEXT, OP_NEXT: begin
                if (r_r == 18'd0) begin
                  r_nxt = r_q; rctl.pop = 1'b1;
                  go = (op == OP_NEXT) ? GO_FETCH : GO_ON;
                end else begin
                  r_nxt = r_r - 18'd1;
                  go = (op == OP_NEXT) ? GO_JUMP : GO_RESTART;
                end
              end
              OP_IF:  go = (t_r == 18'd0) ? GO_JUMP : GO_FETCH;
              OP_MIF: go = !t_r[17] ? GO_JUMP : GO_FETCH;
              OP_FETCH_P, OP_FETCH_PLUS, OP_FETCH_B, OP_FETCH_A: begin
                if (op == OP_FETCH_P) pc_nxt = pc_inc;
                if (op == OP_FETCH_PLUS) a_nxt = a_inc;
                o.io_access = m_io;
                o.io_address = m_io ? maddr : 18'd0;
                dctl.push = 1'b1; dctl.data = s_r; s_nxt = t_r; t_nxt = rdv;
              end
              OP_STORE_P, OP_STORE_PLUS, OP_STORE_B, OP_STORE_A: begin
                if (op == OP_STORE_P) pc_nxt = pc_inc;
                if (op == OP_STORE_PLUS) a_nxt = a_inc;
                if (m_ram) ram_we = 1'b1;
                else if (m_rom) o.rom_write_attempt = 1'b1;
                else begin
                  o.io_access = 1'b1; o.io_is_write = 1'b1;
                  o.io_address = maddr; o.io_write_data = t_r;
                end
                t_nxt = s_r; s_nxt = d_q; dctl.pop = 1'b1;
              end
              OP_MUL_STEP: begin
                s20 = {{2{t_r[17]}}, t_r};
                if (a_r[0]) begin
                  s20 = s20 + {{2{s_r[17]}}, s_r} + {19'd0, ext & c_r};
                  if (ext) c_nxt = s20[18];
                end
                a_nxt = {s20[0], a_r[17:1]};
                t_nxt = {s20[18] | s20[17], s20[17:1]};
              end
              OP_SHL: t_nxt = {t_r[16:0], 1'b0};
              OP_SHR: t_nxt = {t_r[17], t_r[17:1]};
              OP_NOT: t_nxt = ~t_r;
              OP_ADD, OP_AND, OP_XOR: begin
                s20 = {{2{t_r[17]}}, t_r} + {{2{s_r[17]}}, s_r} + {19'd0, ext & c_r};
                if (op == OP_ADD) begin
                  sum = s20[17:0];
                  if (ext) c_nxt = s20[18];
                end else if (op == OP_AND) sum = t_r & s_r;
                else sum = t_r ^ s_r;
                t_nxt = sum; s_nxt = d_q; dctl.pop = 1'b1;
              end
              OP_DROP: begin
                t_nxt = s_r; s_nxt = d_q; dctl.pop = 1'b1;
              end
              OP_DUP: begin
                dctl.push = 1'b1; dctl.data = s_r; s_nxt = t_r;
              end
              OP_POP: begin
                dctl.push = 1'b1; dctl.data = s_r; s_nxt = t_r; t_nxt = r_r;
                r_nxt = r_q; rctl.pop = 1'b1;
              end
              OP_OVER: begin
                dctl.push = 1'b1; dctl.data = s_r; t_nxt = s_r; s_nxt = t_r;
              end
              OP_READ_A: begin
                dctl.push = 1'b1; dctl.data = s_r; s_nxt = t_r; t_nxt = a_r;
              end
              OP_NOP: go = GO_ON;
              OP_PUSH: begin
                rctl.push = 1'b1; rctl.data = r_r; r_nxt = t_r;
                t_nxt = s_r; s_nxt = d_q; dctl.pop = 1'b1;
              end
              OP_SET_B: begin
                b_nxt = t_r; t_nxt = s_r; s_nxt = d_q; dctl.pop = 1'b1;
              end
              OP_SET_A: begin
                a_nxt = t_r; t_nxt = s_r; s_nxt = d_q; dctl.pop = 1'b1;
              end
              default: go = GO_ON;
            endcase
            // slot sequencing; jump targets come from the undecoded word
            unique case (go)
              GO_ON:      slot_nxt = (k == 2'd3) ? 3'd0 : 3'({1'b0, k}) + 3'd2;
              GO_RESTART: slot_nxt = 3'd1;
              GO_FETCH:   slot_nxt = 3'd0;
              default: begin
                slot_nxt = 3'd0;
                if (k == 2'd0) pc_nxt = iw_r[9:0];
                else if (k == 2'd1) pc_nxt = {2'b00, iw_r[7:0]};
                else if (k == 2'd2) pc_nxt = {7'd0, iw_r[2:0]};
              end
            endcase
          end
        end
        CMD_LOAD_ROM: rom_we = 1'b1;
        CMD_LOAD_RAM: begin
          ram_we = 1'b1; ram_wa = lidx; ram_wd = item_r.load_data;
        end
        default: begin
          pc_nxt = item_r.start_address; slot_nxt = 3'd0;
        end
      endcase
    end
    o.program_counter = pc_nxt;
    o.top_of_stack    = t_nxt;
  end

  assign out_valid_nxt = busy_r ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r <= '0; s_r <= '0; r_r <= '0; a_r <= '0; b_r <= '0; c_r <= 1'b0;
      pc_r <= '0; iw_r <= '0; slot_r <= '0;
      busy_r <= 1'b0; out_valid_r <= 1'b0;
    end else begin
      t_r <= t_nxt; s_r <= s_nxt; r_r <= r_nxt; a_r <= a_nxt; b_r <= b_nxt;
      c_r <= c_nxt; pc_r <= pc_nxt; iw_r <= iw_nxt; slot_r <= slot_nxt;
      busy_r <= accept;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
    if (busy_r) out_r <= o;
  end

  fcpu_ram #(.WIDTH(18), .DEPTH(MEM_WORDS)) u_ram (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
    .rd_addr(midx), .rd_data(ram_q)
  );

  fcpu_ram #(.WIDTH(18), .DEPTH(MEM_WORDS)) u_rom (
    .clk(clk), .wr_en(rom_we), .wr_addr(lidx), .wr_data(item_r.load_data),
    .rd_addr(midx), .rd_data(rom_q)
  );

  fcpu_ring #(.DEPTH(STACK_DEPTH)) u_dring (
    .clk(clk), .rst_n(rst_n), .ctl(dctl), .pop_data(d_q)
  );

  fcpu_ring #(.DEPTH(STACK_DEPTH)) u_rring (
    .clk(clk), .rst_n(rst_n), .ctl(rctl), .pop_data(r_q)
  );

  // execute is never held, follows every accepted beat and always lands in the output register
  `CHK_NEXT(a_exec_once, busy_r, !busy_r, "execute held past one cycle")
  `CHK_NEXT(a_accept_exec, accept, busy_r, "accepted beat not executed")
  `CHK_NEXT(a_exec_out, busy_r, out_valid_r, "executed beat not presented")
  `CHK_ALWAYS(a_ring_excl, !(dctl.push && dctl.pop) && !(rctl.push && rctl.pop), "ring pushed and popped at once")
endmodule
